FILE: sv/qbvq_pkg.sv
// ----------------------------------------------------------------------------
// Quantized BV tree box query package
// Shared types, register indexes and constants for the box query core.
// ----------------------------------------------------------------------------
package qbvq_pkg;

  localparam int NODES_DEF    = 1024;
  localparam int MAX_HITS_DEF = 64;
  localparam int CMD_DEPTH    = 4;
  localparam int RES_DEPTH    = 4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [2:0] REG_TILE_MIN_X  = 3'd0;
  localparam logic [2:0] REG_TILE_MIN_Y  = 3'd1;
  localparam logic [2:0] REG_TILE_MIN_Z  = 3'd2;
  localparam logic [2:0] REG_TILE_MAX_X  = 3'd3;
  localparam logic [2:0] REG_TILE_MAX_Y  = 3'd4;
  localparam logic [2:0] REG_TILE_MAX_Z  = 3'd5;
  localparam logic [2:0] REG_QUANT_SCALE = 3'd6;
  localparam logic [2:0] REG_NODE_COUNT  = 3'd7;

  localparam logic [31:0] QUANT_SCALE_RST = 32'h0001_0000;
  localparam logic [15:0] QMIN_MASK       = 16'hfffe;
  localparam logic [15:0] QBOUND_SAT      = 16'hffff;

  typedef logic [2:0][31:0] axis_word_t;

  typedef struct packed {
    logic [47:0] min_b;
    logic [47:0] max_b;
    logic [16:0] value;
  } node_t;

  typedef struct packed {
    logic       is_query;
    logic [9:0] idx;
    node_t      node;
  } cmd_t;

  typedef struct packed {
    logic [15:0] poly_index;
    logic        hit_valid;
    logic        last;
    logic [6:0]  hit_count;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_QUANT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    PH_CLAMP,
    PH_MUL_LO,
    PH_MUL_HI,
    PH_SAT
  } quant_phase_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_WALK,
    W_FLUSH
  } walk_state_t;

endpackage

FILE: sv/qbvq_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer used between the block's stages.
// ----------------------------------------------------------------------------
module qbvq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0][WIDTH-1:0] store;
  logic [PW:0] wr_ptr;
  logic [PW:0] rd_ptr;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[PW] != rd_ptr[PW]) && (wr_ptr[PW-1:0] == rd_ptr[PW-1:0]);
  assign rd_data = store[rd_ptr[PW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      store[wr_ptr[PW-1:0]] <= wr_data;
    end
  end

endmodule

FILE: sv/qbvq_front.sv
// ----------------------------------------------------------------------------
// Box query front end
// Accepts input items, forwards node loads and quantizes query boxes with
// one shared multiplier before queueing them for the tree walker.
// ----------------------------------------------------------------------------
module qbvq_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  req_type,
  input  logic [9:0]            node_index,
  input  logic signed [31:0]    box_min_x,
  input  logic signed [31:0]    box_min_y,
  input  logic signed [31:0]    box_min_z,
  input  logic signed [31:0]    box_max_x,
  input  logic signed [31:0]    box_max_y,
  input  logic signed [31:0]    box_max_z,
  input  logic signed [16:0]    node_value,
  input  qbvq_pkg::axis_word_t  tile_min,
  input  qbvq_pkg::axis_word_t  tile_max,
  input  logic [31:0]           quant_scale,
  output logic                  cmd_push,
  output qbvq_pkg::cmd_t        cmd,
  input  logic                  cmd_full
);

  import qbvq_pkg::*;

  front_state_t         state;
  front_state_t         state_next;
  quant_phase_t         phase;
  logic [5:0][31:0]     box;
  logic [5:0][15:0]     qb;
  logic [2:0]           k;
  logic [32:0]          d_reg;
  logic                 d_pos;
  logic [48:0]          prod;
  logic [49:0]          sum;
  logic                 accept;
  logic                 start;
  logic [1:0]           axis;
  logic                 is_min;
  logic signed [31:0]   q;
  logic signed [31:0]   lo;
  logic signed [31:0]   hi;
  logic signed [31:0]   c;
  logic signed [33:0]   d_full;
  logic [15:0]          mul_b;
  logic [48:0]          mul;
  logic [15:0]          f;
  logic [15:0]          f_inc;
  logic [15:0]          qb_new;

  assign accept = push && !full;
  assign start  = accept && (req_type == REQ_QUERY);

  assign axis   = (k >= 3'd3) ? 2'(k - 3'd3) : k[1:0];
  assign is_min = (k < 3'd3);
  assign q      = $signed(box[k]);
  assign lo     = $signed(tile_min[axis]);
  assign hi     = $signed(tile_max[axis]);
  assign c      = (q < lo) ? lo : ((q > hi) ? hi : q);
  assign d_full = 34'(c) - 34'(lo);

  assign mul_b  = (phase == PH_MUL_LO) ? quant_scale[15:0] : quant_scale[31:16];
  assign mul    = d_reg * mul_b;

  assign f      = (sum[49:24] != '0) ? QBOUND_SAT : sum[23:8];
  assign f_inc  = (f == QBOUND_SAT) ? QBOUND_SAT : f + 16'd1;
  assign qb_new = is_min ? (d_pos ? (f & QMIN_MASK) : 16'd0)
                         : (d_pos ? (f_inc | 16'd1) : 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      phase <= PH_CLAMP;
      k     <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        phase <= PH_CLAMP;
        k     <= '0;
      end else if (state == F_QUANT) begin
        case (phase)
          PH_CLAMP:  phase <= PH_MUL_LO;
          PH_MUL_LO: phase <= PH_MUL_HI;
          PH_MUL_HI: phase <= PH_SAT;
          PH_SAT: begin
            phase <= PH_CLAMP;
            k     <= k + 3'd1;
          end
          default: phase <= PH_CLAMP;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      box <= {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x};
    end
    if (state == F_QUANT) begin
      case (phase)
        PH_CLAMP: begin
          d_reg <= d_full[32:0];
          d_pos <= !d_full[33] && (d_full != '0);
        end
        PH_MUL_LO: prod <= mul;
        PH_MUL_HI: sum <= 50'(mul) + 50'(prod[48:16]);
        PH_SAT:    qb[k] <= qb_new;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    full       = (state != F_IDLE) || cmd_full;
    cmd_push   = 1'b0;
    cmd        = '0;
    case (state)
      F_IDLE: begin
        cmd.is_query     = REQ_LOAD;
        cmd.idx          = node_index;
        cmd.node.min_b   = {box_min_z[15:0], box_min_y[15:0], box_min_x[15:0]};
        cmd.node.max_b   = {box_max_z[15:0], box_max_y[15:0], box_max_x[15:0]};
        cmd.node.value   = node_value;
        if (accept) begin
          if (req_type == REQ_QUERY) begin
            state_next = F_QUANT;
          end else begin
            cmd_push = 1'b1;
          end
        end
      end
      F_QUANT: begin
        if (phase == PH_SAT && k == 3'd5) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd.is_query   = REQ_QUERY;
        cmd.node.min_b = {qb[2], qb[1], qb[0]};
        cmd.node.max_b = {qb[5], qb[4], qb[3]};
        if (!cmd_full) begin
          cmd_push   = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

FILE: sv/qbvq_walker.sv
// ----------------------------------------------------------------------------
// Tree walker
// Holds the node table, applies node loads, walks the flattened tree for each
// quantized query, one node per cycle unless stalled, emitting leaf hits.
// ----------------------------------------------------------------------------
module qbvq_walker #(
  parameter int NODES    = qbvq_pkg::NODES_DEF,
  parameter int MAX_HITS = qbvq_pkg::MAX_HITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  qbvq_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  input  logic [10:0]     node_count,
  output logic            res_push,
  output qbvq_pkg::res_t  res_data,
  input  logic            res_full
);

  import qbvq_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  node_t            table_mem [NODES];
  node_t            rd_data;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  walk_state_t      state;
  walk_state_t      state_next;
  logic [47:0]      qmin;
  logic [47:0]      qmax;
  logic [17:0]      count_r;
  logic [17:0]      count_lim;
  logic [AW-1:0]    cur_pos;
  res_t             pend;
  logic             pend_valid;
  logic [6:0]       hits;
  logic [6:0]       hits_inc;
  logic             start;
  logic             advance;
  logic             take;
  logic             finish;
  logic [2:0]       axis_ok;
  logic             overlap;
  logic             leaf;
  logic             hit;
  logic [17:0]      esc;
  logic [17:0]      nxt;

  assign count_lim = ({7'd0, node_count} > 18'(NODES)) ? 18'(NODES) : {7'd0, node_count};
  assign hits_inc  = hits + 7'd1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_ok[a] = !((qmin[16*a +: 16] > rd_data.max_b[16*a +: 16]) ||
                     (qmax[16*a +: 16] < rd_data.min_b[16*a +: 16]));
    end
  end

  assign overlap = &axis_ok;
  assign leaf    = !rd_data.value[16];
  assign hit     = leaf && overlap;
  assign esc     = 18'h20000 - {1'b0, rd_data.value};
  assign nxt     = (overlap || leaf) ? 18'(cur_pos) + 18'd1 : 18'(cur_pos) + esc;

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = cur_pos;
    res_push   = 1'b0;
    res_data   = pend;
    start      = 1'b0;
    advance    = 1'b0;
    take       = 1'b0;
    finish     = 1'b0;
    case (state)
      W_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.is_query == REQ_QUERY) begin
            start      = 1'b1;
            rd_addr    = '0;
            state_next = (count_lim == '0) ? W_FLUSH : W_WALK;
          end else begin
            mem_we = (17'(cmd.idx) < 17'(NODES));
          end
        end
      end
      W_WALK: begin
        if (!(hit && pend_valid && res_full)) begin
          advance = 1'b1;
          if (hit) begin
            take     = 1'b1;
            res_push = pend_valid;
          end
          if ((nxt >= count_r) || (hit && (hits_inc == 7'(MAX_HITS)))) begin
            state_next = W_FLUSH;
          end else begin
            rd_addr = nxt[AW-1:0];
          end
        end
      end
      W_FLUSH: begin
        if (!res_full) begin
          res_push   = 1'b1;
          finish     = 1'b1;
          state_next = W_IDLE;
          if (pend_valid) begin
            res_data.last = 1'b1;
          end else begin
            res_data = '{poly_index: 16'd0, hit_valid: 1'b0, last: 1'b1, hit_count: 7'd0};
          end
        end
      end
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[AW'(cmd.idx)] <= cmd.node;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= W_IDLE;
      pend_valid <= 1'b0;
      hits       <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        pend_valid <= 1'b0;
        hits       <= '0;
      end else if (take) begin
        pend_valid <= 1'b1;
        hits       <= hits_inc;
      end else if (finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qmin    <= cmd.node.min_b;
      qmax    <= cmd.node.max_b;
      count_r <= count_lim;
      cur_pos <= '0;
    end else if (advance) begin
      cur_pos <= nxt[AW-1:0];
    end
    if (take) begin
      pend <= '{poly_index: rd_data.value[15:0], hit_valid: 1'b1, last: 1'b0,
                hit_count: hits_inc};
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    hits <= 7'(MAX_HITS))
    else $error("hit count exceeds the limit");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == W_WALK) |-> (18'(cur_pos) < count_r))
    else $error("walk position outside the node range");

  a_take_sets_pending: assert property (@(posedge clk) disable iff (rst)
    take |=> (pend_valid && pend.hit_valid))
    else $error("hit was not held as pending");

endmodule

FILE: sv/quantized_bv_tree_box_query_core.sv
// ----------------------------------------------------------------------------
// Quantized BV tree box query core
// Node table loader and stackless box query over a flattened, quantized tree.
// ----------------------------------------------------------------------------
// Input items enter through push/full. A node load (req_type 0) writes one
// slot of the node table. A box query (req_type 1) is clamped to the tile box,
// quantized and checked against the tree; every overlapping leaf, up to
// MAX_HITS of them, produces one result, the final one flagged by last. A
// query without hits gives a single result with hit_valid low. Results leave
// through empty/pop in order. Configuration is written through
// cfg_write/cfg_index/cfg_data; the user must write it only while idle, as
// the block does not enforce this. The quantizer runs six bounds through one
// 33x16 multiplier in four steps each; the walker then starts, visits one
// node at a time (the node table read port is the loop) and closes the
// query. A small command queue lets the quantizer work on the next item
// while the walker runs. Reset clears the configuration to its defaults and
// empties all queues; the node table is not cleared. When pop stays low the
// result queue fills and the walker waits, and then the command queue and
// the input stall in turn.
// ----------------------------------------------------------------------------
module quantized_bv_tree_box_query_core #(
  parameter int NODES    = qbvq_pkg::NODES_DEF,
  parameter int MAX_HITS = qbvq_pkg::MAX_HITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic [9:0]         node_index,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_min_z,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  input  logic signed [16:0] node_value,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        poly_index,
  output logic               hit_valid,
  output logic               last,
  output logic [6:0]         hit_count,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import qbvq_pkg::*;

  axis_word_t   tile_min;
  axis_word_t   tile_max;
  logic [31:0]  quant_scale;
  logic [10:0]  node_count;
  cmd_t         cmd_in;
  cmd_t         cmd_out;
  logic         cmd_push;
  logic         cmd_full;
  logic         cmd_pop;
  logic         cmd_empty;
  res_t         res_in;
  res_t         res_out;
  logic         res_push;
  logic         res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_min    <= '0;
      tile_max    <= '0;
      quant_scale <= QUANT_SCALE_RST;
      node_count  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TILE_MIN_X:  tile_min[0]  <= cfg_data;
        REG_TILE_MIN_Y:  tile_min[1]  <= cfg_data;
        REG_TILE_MIN_Z:  tile_min[2]  <= cfg_data;
        REG_TILE_MAX_X:  tile_max[0]  <= cfg_data;
        REG_TILE_MAX_Y:  tile_max[1]  <= cfg_data;
        REG_TILE_MAX_Z:  tile_max[2]  <= cfg_data;
        REG_QUANT_SCALE: quant_scale <= cfg_data;
        REG_NODE_COUNT:  node_count  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  qbvq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .node_index  (node_index),
    .box_min_x   (box_min_x),
    .box_min_y   (box_min_y),
    .box_min_z   (box_min_z),
    .box_max_x   (box_max_x),
    .box_max_y   (box_max_y),
    .box_max_z   (box_max_z),
    .node_value  (node_value),
    .tile_min    (tile_min),
    .tile_max    (tile_max),
    .quant_scale (quant_scale),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  qbvq_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  qbvq_walker #(
    .NODES    (NODES),
    .MAX_HITS (MAX_HITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .node_count (node_count),
    .res_push   (res_push),
    .res_data   (res_in),
    .res_full   (res_full)
  );

  qbvq_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign poly_index = res_out.poly_index;
  assign hit_valid  = res_out.hit_valid;
  assign last       = res_out.last;
  assign hit_count  = res_out.hit_count;

endmodule
